[rtl/fdfi_pkg.sv]
// Package for the frame delivery fault injector: item structs, field widths,
// kind/fate/origin codes and parameter defaults. No dependencies.
package fdfi_pkg;

  localparam int HANDLE_W = 32;
  localparam int BYTES_W  = 10;
  localparam int DELAY_W  = 8;
  localparam int COUNT_W  = 32;

  // At most six results per item; aging may use four of them
  localparam int RESULT_CAP = 6;
  localparam int AGE_CAP    = 4;
  localparam int RES_W      = 3;

  localparam int HOLD_SLOTS_DEF      = 4;
  localparam int MAX_FRAME_BYTES_DEF = 640;

  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [1:0] FATE_DELIVER   = 2'd0;
  localparam logic [1:0] FATE_DROP      = 2'd1;
  localparam logic [1:0] FATE_REORDER   = 2'd2;
  localparam logic [1:0] FATE_DUPLICATE = 2'd3;

  localparam logic [1:0] ORIGIN_AGED    = 2'd0;
  localparam logic [1:0] ORIGIN_CURRENT = 2'd1;
  localparam logic [1:0] ORIGIN_DUP     = 2'd2;
  localparam logic [1:0] ORIGIN_FLUSH   = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] frame_handle;
    logic [BYTES_W-1:0]  frame_bytes;
    logic [1:0]          fate;
    logic [DELAY_W-1:0]  hold_delay;
  } in_item_t;

  typedef struct packed {
    logic                frame_present;
    logic [HANDLE_W-1:0] out_handle;
    logic [BYTES_W-1:0]  out_bytes;
    logic [1:0]          origin;
    logic                last;
    logic [COUNT_W-1:0]  delivered_count;
    logic [COUNT_W-1:0]  dropped_count;
    logic [COUNT_W-1:0]  reordered_count;
    logic [COUNT_W-1:0]  duplicated_count;
    logic [COUNT_W-1:0]  unheld_count;
    logic [COUNT_W-1:0]  flushed_count;
  } out_item_t;

  // One buffered frame awaiting emission
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  bytes;
    logic [1:0]          origin;
  } res_ent_t;

endpackage

[rtl/frame_delivery_fault_injector.sv]
// Frame delivery fault injector: hold-slot sequencer, result buffer, counters.
// Depends on fdfi_pkg.
//
// Usage
//   Input channel (in_valid/in_ready/in_data): one item is an offered frame
//   with its fate and hold delay, or a flush command. in_ready is high only
//   while the sequencer is idle; one item is worked on at a time.
//   Result channel (out_valid/out_ready/out_data): one to six result items per
//   input item, the final one marked by last. Every result carries the six
//   event counters as they stand after the whole input item.
// Sequence
//   After acceptance the sequencer walks the hold slots one per cycle
//   through a single decrement/compare unit. An offer then passes the fate
//   state (and the duplicate state for a duplicate); a flush skips them. One
//   result per cycle is handed out from a small buffer while the receiver
//   takes them, then the sequencer returns to idle.
// Reset and stall
//   Reset (rst_n low, synchronous) frees all slots and clears the counters.
//   The result sits in an output register; while the receiver stalls the
//   sequencer waits in its emit phase, and the next input item may be taken
//   once the last result has been loaded.
module frame_delivery_fault_injector
  import fdfi_pkg::*;
#(
  parameter int HOLD_SLOTS      = HOLD_SLOTS_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1;
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(HOLD_SLOTS - 1);
  localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(MAX_FRAME_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_FATE, S_DUP, S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  logic [RES_W-1:0]   nres_r, nres_nxt;
  logic [RES_W-1:0]   emit_r, emit_nxt;
  logic [DELAY_W-1:0] rem_r [HOLD_SLOTS];
  logic [DELAY_W-1:0] rem_nxt [HOLD_SLOTS];
  logic [COUNT_W-1:0] dlv_r, dlv_nxt, drp_r, drp_nxt, reo_r, reo_nxt;
  logic [COUNT_W-1:0] dup_r, dup_nxt, unh_r, unh_nxt, flu_r, flu_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // Slot payload store and result buffer
  logic [HANDLE_W-1:0] hdl_r [HOLD_SLOTS];
  logic [BYTES_W-1:0]  byt_r [HOLD_SLOTS];
  res_ent_t            buf_r [RESULT_CAP];

  logic             push_en;
  res_ent_t         push_ent;
  logic             slot_wr_en;

  // Shared slot unit: look at the walked slot
  logic [DELAY_W-1:0] cur_rem;
  logic               rem_zero, rem_one;
  logic [DELAY_W-1:0] delay_eff;
  logic               emit_last;
  res_ent_t           emit_ent;

  assign cur_rem   = rem_r[idx_r];
  assign rem_zero  = (cur_rem == '0);
  assign rem_one   = (cur_rem == DELAY_W'(1));
  assign delay_eff = (item_r.hold_delay == '0) ? DELAY_W'(1) : item_r.hold_delay;
  assign emit_last = (nres_r == '0) || (emit_r == nres_r - RES_W'(1));
  assign emit_ent  = buf_r[emit_r];

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    nres_nxt      = nres_r;
    emit_nxt      = emit_r;
    rem_nxt       = rem_r;
    dlv_nxt       = dlv_r;
    drp_nxt       = drp_r;
    reo_nxt       = reo_r;
    dup_nxt       = dup_r;
    unh_nxt       = unh_r;
    flu_nxt       = flu_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    push_en       = 1'b0;
    push_ent      = '{handle: item_r.frame_handle, bytes: item_r.frame_bytes,
                      origin: ORIGIN_CURRENT};
    slot_wr_en    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          nres_nxt  = '0;
          emit_nxt  = '0;
          state_nxt = S_WALK;
        end
      end

      // One slot per cycle: flush release, or aging with release
      S_WALK: begin
        push_ent.handle = hdl_r[idx_r];
        push_ent.bytes  = byt_r[idx_r];
        if (item_r.kind == KIND_FLUSH) begin
          push_ent.origin = ORIGIN_FLUSH;
          if (!rem_zero && nres_r < RES_W'(RESULT_CAP)) begin
            push_en        = 1'b1;
            rem_nxt[idx_r] = '0;
            flu_nxt        = flu_r + COUNT_W'(1);
          end
        end else begin
          push_ent.origin = ORIGIN_AGED;
          if (rem_zero) begin
            if (!found_r) begin
              found_nxt = 1'b1;
              free_nxt  = idx_r;
            end
          end else if (rem_one) begin
            // releases beyond the cap stay due for the next offer
            if (nres_r < RES_W'(AGE_CAP)) begin
              push_en        = 1'b1;
              rem_nxt[idx_r] = '0;
              if (!found_r) begin
                found_nxt = 1'b1;
                free_nxt  = idx_r;
              end
            end
          end else begin
            rem_nxt[idx_r] = cur_rem - DELAY_W'(1);
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = (item_r.kind == KIND_FLUSH) ? S_EMIT : S_FATE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_FATE: begin
        if (item_r.fate == FATE_DROP) begin
          drp_nxt   = drp_r + COUNT_W'(1);
          state_nxt = S_EMIT;
        end else if (item_r.fate == FATE_REORDER && found_r &&
                     item_r.frame_bytes <= MAX_BYTES) begin
          slot_wr_en      = 1'b1;
          rem_nxt[free_r] = delay_eff;
          reo_nxt         = reo_r + COUNT_W'(1);
          state_nxt       = S_EMIT;
        end else begin
          if (item_r.fate == FATE_REORDER) begin
            unh_nxt = unh_r + COUNT_W'(1);
          end
          push_en   = 1'b1;
          dlv_nxt   = dlv_r + COUNT_W'(1);
          state_nxt = (item_r.fate == FATE_DUPLICATE) ? S_DUP : S_EMIT;
        end
      end

      S_DUP: begin
        push_ent.origin = ORIGIN_DUP;
        push_en         = 1'b1;
        dup_nxt         = dup_r + COUNT_W'(1);
        state_nxt       = S_EMIT;
      end

      // Counters are final here; hand out one result per free output slot
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.frame_present    = (nres_r != '0);
          out_data_nxt.out_handle       = (nres_r != '0) ? emit_ent.handle : '0;
          out_data_nxt.out_bytes        = (nres_r != '0) ? emit_ent.bytes : '0;
          out_data_nxt.origin           = (nres_r != '0) ? emit_ent.origin
                                                         : ORIGIN_AGED;
          out_data_nxt.last             = emit_last;
          out_data_nxt.delivered_count  = dlv_r;
          out_data_nxt.dropped_count    = drp_r;
          out_data_nxt.reordered_count  = reo_r;
          out_data_nxt.duplicated_count = dup_r;
          out_data_nxt.unheld_count     = unh_r;
          out_data_nxt.flushed_count    = flu_r;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt = emit_r + RES_W'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (push_en) begin
      nres_nxt = nres_r + RES_W'(1);
    end
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      free_r      <= '0;
      nres_r      <= '0;
      emit_r      <= '0;
      dlv_r       <= '0;
      drp_r       <= '0;
      reo_r       <= '0;
      dup_r       <= '0;
      unh_r       <= '0;
      flu_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HOLD_SLOTS; i++) begin
        rem_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      nres_r      <= nres_nxt;
      emit_r      <= emit_nxt;
      dlv_r       <= dlv_nxt;
      drp_r       <= drp_nxt;
      reo_r       <= reo_nxt;
      dup_r       <= dup_nxt;
      unh_r       <= unh_nxt;
      flu_r       <= flu_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  // Slot payload and result buffer writes
  always_ff @(posedge clk) begin
    if (slot_wr_en) begin
      hdl_r[free_r] <= item_r.frame_handle;
      byt_r[free_r] <= item_r.frame_bytes;
    end
    if (push_en) begin
      buf_r[nres_r] <= push_ent;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted item keeps the input closed for the walk
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again straight after an accept");

  // The result buffer never overfills
  a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= RES_W'(RESULT_CAP))
    else $error("result buffer overflow");

  // An empty result is always the only, hence last, one
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.frame_present) |-> out_data.last)
    else $error("empty result not marked last");

endmodule

[tb/fdfi_delivery_checker.sv]
`timescale 1ns / 100ps
// Delivery checker for the frame delivery fault injector: predicts the result
// items of every accepted input item and compares them. Depends on fdfi_pkg.
module fdfi_delivery_checker
  import fdfi_pkg::*;
#(
  parameter int HOLD_SLOTS      = HOLD_SLOTS_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        results_owed
);

  // Predicted hold slots and event counters
  logic [DELAY_W-1:0]  hold_left   [HOLD_SLOTS];
  logic [HANDLE_W-1:0] hold_handle [HOLD_SLOTS];
  logic [BYTES_W-1:0]  hold_bytes  [HOLD_SLOTS];
  logic [COUNT_W-1:0]  n_delivered, n_dropped, n_reordered;
  logic [COUNT_W-1:0]  n_duplicated, n_unheld, n_flushed;

  // Results of the item being predicted, then the queue of owed results
  out_item_t step_buf [RESULT_CAP];
  int        step_n;
  out_item_t owed_results [$];

  function automatic void emit_frame(logic [HANDLE_W-1:0] h, logic [BYTES_W-1:0] b,
                                     logic [1:0] o);
    if (step_n < RESULT_CAP) begin
      step_buf[step_n]               = '0;
      step_buf[step_n].frame_present = 1'b1;
      step_buf[step_n].out_handle    = h;
      step_buf[step_n].out_bytes     = b;
      step_buf[step_n].origin        = o;
      step_n++;
    end
  endfunction

  // Empty step gives one blank result; all results carry the final counters
  function automatic void close_step();
    int k;
    if (step_n == 0) begin
      step_buf[0] = '0;
      step_n      = 1;
    end
    for (k = 0; k < step_n; k++) begin
      step_buf[k].last             = (k == step_n - 1);
      step_buf[k].delivered_count  = n_delivered;
      step_buf[k].dropped_count    = n_dropped;
      step_buf[k].reordered_count  = n_reordered;
      step_buf[k].duplicated_count = n_duplicated;
      step_buf[k].unheld_count     = n_unheld;
      step_buf[k].flushed_count    = n_flushed;
      owed_results.push_back(step_buf[k]);
    end
  endfunction

  function automatic void apply_impairment(in_item_t it);
    logic [DELAY_W-1:0] delay;
    int s;
    int free_slot;
    step_n = 0;
    if (it.kind == KIND_FLUSH) begin
      for (s = 0; s < HOLD_SLOTS; s++) begin
        if (hold_left[s] != '0 && step_n < RESULT_CAP) begin
          emit_frame(hold_handle[s], hold_bytes[s], ORIGIN_FLUSH);
          hold_left[s] = '0;
          n_flushed++;
        end
      end
    end else begin
      // ageing in slot order; keep room for the current frame twice
      for (s = 0; s < HOLD_SLOTS; s++) begin
        if (hold_left[s] == 1) begin
          if (step_n < RESULT_CAP - 2) begin
            emit_frame(hold_handle[s], hold_bytes[s], ORIGIN_AGED);
            hold_left[s] = '0;
          end
        end else if (hold_left[s] != '0) begin
          hold_left[s]--;
        end
      end
      delay = (it.hold_delay == '0) ? DELAY_W'(1) : it.hold_delay;
      free_slot = -1;
      if (it.fate == FATE_REORDER && it.frame_bytes <= MAX_FRAME_BYTES) begin
        for (s = HOLD_SLOTS - 1; s >= 0; s--)
          if (hold_left[s] == '0) free_slot = s;
      end
      if (it.fate == FATE_DROP) begin
        n_dropped++;
      end else if (free_slot >= 0) begin
        hold_handle[free_slot] = it.frame_handle;
        hold_bytes[free_slot]  = it.frame_bytes;
        hold_left[free_slot]   = delay;
        n_reordered++;
      end else begin
        if (it.fate == FATE_REORDER) n_unheld++;
        emit_frame(it.frame_handle, it.frame_bytes, ORIGIN_CURRENT);
        n_delivered++;
        if (it.fate == FATE_DUPLICATE) begin
          emit_frame(it.frame_handle, it.frame_bytes, ORIGIN_DUP);
          n_duplicated++;
        end
      end
    end
    close_step();
  endfunction

  task automatic show_item(input string tag, input out_item_t r);
    $display("  %s: present=%0d handle=%h bytes=%0d origin=%0d last=%0d", tag,
             r.frame_present, r.out_handle, r.out_bytes, r.origin, r.last);
    $display("  %s: counts dlv=%0d drp=%0d reo=%0d dup=%0d unh=%0d fls=%0d", tag,
             r.delivered_count, r.dropped_count, r.reordered_count,
             r.duplicated_count, r.unheld_count, r.flushed_count);
  endtask

  // Results are checked before the new item's expectations are queued
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      for (int s = 0; s < HOLD_SLOTS; s++) hold_left[s] = '0;
      n_delivered    = '0;
      n_dropped      = '0;
      n_reordered    = '0;
      n_duplicated   = '0;
      n_unheld       = '0;
      n_flushed      = '0;
      mismatch_count = 0;
      owed_results   = {};
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result item with nothing expected", $time);
            show_item("got", out_data);
          end
        end else begin
          want = owed_results.pop_front();
          if (out_data.frame_present    !== want.frame_present    ||
              out_data.out_handle       !== want.out_handle       ||
              out_data.out_bytes        !== want.out_bytes        ||
              out_data.origin           !== want.origin           ||
              out_data.last             !== want.last             ||
              out_data.delivered_count  !== want.delivered_count  ||
              out_data.dropped_count    !== want.dropped_count    ||
              out_data.reordered_count  !== want.reordered_count  ||
              out_data.duplicated_count !== want.duplicated_count ||
              out_data.unheld_count     !== want.unheld_count     ||
              out_data.flushed_count    !== want.flushed_count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result item mismatch", $time);
              show_item("exp", want);
              show_item("got", out_data);
            end
          end
        end
      end
      if (in_valid && in_ready) apply_impairment(in_data);
    end
    results_owed = owed_results.size();
  end

endmodule

[tb/tb_frame_delivery_fault_injector.sv]
`timescale 1ns / 100ps
// Top of the fault injector testbench: clock, reset, directed and random items,
// handshake idling and the verdict. Depends on fdfi_pkg and fdfi_delivery_checker.
module tb_frame_delivery_fault_injector;
  import fdfi_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        mismatches;
  int        results_owed;
  int        idle_pct  = 0;
  int        stall_pct = 0;

  frame_delivery_fault_injector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  fdfi_delivery_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatches),
    .results_owed   (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic in_item_t offer(logic [HANDLE_W-1:0] h, logic [BYTES_W-1:0] b,
                                     logic [1:0] f, logic [DELAY_W-1:0] d);
    in_item_t it;
    it.kind         = KIND_OFFER;
    it.frame_handle = h;
    it.frame_bytes  = b;
    it.fate         = f;
    it.hold_delay   = d;
    return it;
  endfunction

  // Mostly short holds and legal lengths, with long holds to fill the slots
  function automatic in_item_t random_item();
    in_item_t it;
    it.kind         = ($urandom_range(0, 99) < 7) ? KIND_FLUSH : KIND_OFFER;
    it.frame_handle = $urandom;
    if ($urandom_range(0, 99) < 85) begin
      it.frame_bytes = BYTES_W'($urandom_range(0, MAX_FRAME_BYTES_DEF));
    end else begin
      it.frame_bytes = BYTES_W'($urandom_range(MAX_FRAME_BYTES_DEF + 1, 1023));
    end
    case ($urandom_range(0, 9))
      0, 1:    it.fate = FATE_DELIVER;
      2, 3:    it.fate = FATE_DROP;
      4, 5, 6: it.fate = FATE_REORDER;
      default: it.fate = FATE_DUPLICATE;
    endcase
    if ($urandom_range(0, 99) < 70) begin
      it.hold_delay = DELAY_W'($urandom_range(0, 6));
    end else begin
      it.hold_delay = DELAY_W'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    in_item_t flush_cmd;
    flush_cmd      = '0;
    flush_cmd.kind = KIND_FLUSH;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty flush, field extremes, every fate
    send_item(flush_cmd);
    send_item(offer(32'h0000_0000, 10'd0, FATE_DELIVER, 8'd0));
    send_item(offer(32'hFFFF_FFFF, 10'd1023, FATE_DELIVER, 8'd255));
    send_item(offer(32'h0000_00D1, 10'd5, FATE_DROP, 8'd3));
    send_item(offer(32'h1234_5678, 10'd640, FATE_DUPLICATE, 8'd1));
    // zero hold taken as one, released by the next offer
    send_item(offer(32'hA000_0001, 10'd640, FATE_REORDER, 8'd0));
    send_item(offer(32'hA000_0002, 10'd17, FATE_DELIVER, 8'd0));
    // too long to hold
    send_item(offer(32'hA000_0003, 10'd641, FATE_REORDER, 8'd2));
    send_item(offer(32'hA000_0004, 10'd1023, FATE_REORDER, 8'd2));
    // four slots fall due together, then a duplicate: six results
    send_item(offer(32'hB000_0000, 10'd1, FATE_REORDER, 8'd4));
    send_item(offer(32'hB000_0001, 10'd2, FATE_REORDER, 8'd3));
    send_item(offer(32'hB000_0002, 10'd3, FATE_REORDER, 8'd2));
    send_item(offer(32'hB000_0003, 10'd4, FATE_REORDER, 8'd1));
    send_item(offer(32'hB000_0004, 10'd5, FATE_DUPLICATE, 8'd9));
    // all slots busy, then a reorder with no free slot
    send_item(offer(32'hC000_0000, 10'd100, FATE_REORDER, 8'd255));
    send_item(offer(32'hC000_0001, 10'd200, FATE_REORDER, 8'd254));
    send_item(offer(32'hC000_0002, 10'd300, FATE_REORDER, 8'd128));
    send_item(offer(32'hC000_0003, 10'd400, FATE_REORDER, 8'd127));
    send_item(offer(32'hC000_0004, 10'd100, FATE_REORDER, 8'd5));
    send_item(offer(32'hC000_0005, 10'd512, FATE_DROP, 8'd0));
    // flush releases every slot, then finds none
    send_item(flush_cmd);
    send_item(flush_cmd);
    // aged release on a drop: only the held frame comes out
    send_item(offer(32'hD000_0000, 10'd33, FATE_REORDER, 8'd1));
    send_item(offer(32'hD000_0001, 10'd44, FATE_DROP, 8'd0));

    // random items over four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (int k = 0; k < 62; k++) send_item(random_item());
    end
    in_valid <= 1'b0;

    // drain, then let the block settle
    while (results_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_frame_delivery_fault_injector: clean");
    end else begin
      $display("tb_frame_delivery_fault_injector: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("tb_frame_delivery_fault_injector: errors");
    $finish;
  end

endmodule
